// File: rtl/mac_learning_switch_forward_assert.svh
// assertion macros used by the mac learning switch datapath
`ifndef MAC_LEARNING_SWITCH_FORWARD_ASSERT_SVH
`define MAC_LEARNING_SWITCH_FORWARD_ASSERT_SVH

// property checked on every rising edge outside reset
`define MLSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define MLSF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/mlsf_pkg.sv
// package with constants, types and helpers of the mac learning switch
package mlsf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NUM_PORTS   = 8;
  localparam int MAC_W       = 48;
  localparam int PORT_W      = 3;
  localparam int EGR_W       = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = MAC_W + PORT_W;

  localparam logic [2:0] REG_PORT_ACTIVE_MASK = 3'd0;
  localparam logic [EGR_W-1:0] PORT_MASK_RESET = '1;

  typedef struct packed {
    logic load;    // item taken, latch header and restart the scan
    logic rd_en;   // read the entry at the scan index
    logic learn;   // append the source if unknown and room left
    logic finish;  // build the result into the output register
  } mlsf_cmd_t;

  typedef struct packed {
    logic idx_done;  // every valid entry has been read
    logic out_free;  // output register can take a new result
  } mlsf_sts_t;

  // ports that exist, as seen in the egress mask
  function automatic logic [EGR_W-1:0] existing_ports();
    logic [EGR_W-1:0] m;
    for (int p = 0; p < EGR_W; p++) begin
      m[p] = (p < NUM_PORTS);
    end
    return m;
  endfunction

endpackage

// File: rtl/mlsf_ctrl.sv
// sequencing state machine of the mac learning switch
module mlsf_ctrl
  import mlsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  mlsf_sts_t sts,
  output mlsf_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEARN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // last compare lands during the cycle that sees idx_done
        if (sts.idx_done) begin
          state_nxt = ST_LEARN;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_LEARN: begin
        cmd.learn = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/mlsf_dp.sv
// datapath of the mac learning switch: mac table, scan compare and result register
module mlsf_dp
  import mlsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mlsf_cmd_t         cmd,
  output mlsf_sts_t         sts,
  input  logic [MAC_W-1:0]  src_mac,
  input  logic [MAC_W-1:0]  dst_mac,
  input  logic [PORT_W-1:0] ingress_port,
  input  logic [EGR_W-1:0]  port_active_mask,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [EGR_W-1:0]  egress_mask,
  output logic              flooded,
  output logic              learned,
  output logic              table_full
);

  `include "mac_learning_switch_forward_assert.svh"

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  logic [MAC_W-1:0]  src_r, dst_r;
  logic [PORT_W-1:0] ing_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  idx_r;
  logic [MAC_W-1:0]  rd_mac_r;
  logic [PORT_W-1:0] rd_port_r;
  logic              rd_vld_r;
  logic              src_hit_r, dst_hit_r;
  logic [PORT_W-1:0] dst_port_r;
  logic              learned_r, full_r;
  logic              out_vld_r;
  logic [EGR_W-1:0]  egress_r;
  logic              flooded_r, out_learned_r, out_full_r;

  logic              room;
  logic              can_learn;
  logic              mem_we;
  logic [EGR_W-1:0]  allowed;

  assign room      = (cnt_r < CNT_W'(TABLE_DEPTH));
  assign can_learn = !src_hit_r && room;
  assign mem_we    = cmd.learn && can_learn;
  assign allowed   = port_active_mask & existing_ports() & ~(EGR_W'(1) << ing_r);

  assign sts.idx_done = (idx_r == cnt_r);
  assign sts.out_free = !out_vld_r || out_tready;

  // table storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= {src_r, ing_r};
    end
    if (cmd.rd_en) begin
      {rd_mac_r, rd_port_r} <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // header hold
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= src_mac;
      dst_r <= dst_mac;
      ing_r <= ingress_port;
    end
  end

  // scan, learn and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      src_hit_r <= 1'b0;
      dst_hit_r <= 1'b0;
      learned_r <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        idx_r     <= '0;
        src_hit_r <= 1'b0;
        dst_hit_r <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_mac_r == src_r) begin
            src_hit_r <= 1'b1;
          end
          // first match from the oldest entry wins
          if (rd_mac_r == dst_r && !dst_hit_r) begin
            dst_hit_r  <= 1'b1;
            dst_port_r <= rd_port_r;
          end
        end
        if (cmd.learn) begin
          learned_r <= can_learn;
          full_r    <= !src_hit_r && !room;
          if (can_learn) begin
            cnt_r <= cnt_r + CNT_W'(1);
            // a fresh source that is also the destination hits its new entry
            if (!dst_hit_r && dst_r == src_r) begin
              dst_hit_r  <= 1'b1;
              dst_port_r <= ing_r;
            end
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      egress_r      <= dst_hit_r ? (allowed & (EGR_W'(1) << dst_port_r)) : allowed;
      flooded_r     <= !dst_hit_r;
      out_learned_r <= learned_r;
      out_full_r    <= full_r;
    end
  end

  assign out_tvalid  = out_vld_r;
  assign egress_mask = egress_r;
  assign flooded     = flooded_r;
  assign learned     = out_learned_r;
  assign table_full  = out_full_r;

  `MLSF_NEVER(a_cnt_bound, cnt_r > CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
  `MLSF_NEVER(a_scan_bound, cmd.rd_en && idx_r >= cnt_r, "read past the filled part")
  `MLSF_ASSERT(a_learn_grows, mem_we |=> cnt_r == $past(cnt_r) + CNT_W'(1), "learn lost")
  `MLSF_NEVER(a_flags_excl, out_vld_r && out_learned_r && out_full_r, "learned and full both set")

endmodule

// File: rtl/mac_learning_switch_forward.sv
// top level of the learning ethernet switch forwarding decision
// usage:
//   in channel (in_tvalid/in_tready/in_tdata) carries one frame header per item:
//   source mac, destination mac and ingress port. out channel carries one
//   forwarding decision per item: egress port mask and flooded, learned and
//   table_full flags. the apb port holds port_active_mask at address 0.
// timing:
//   an item is scanned against the n valid table entries with one table read
//   per cycle, comparing source and destination together, then the source is
//   appended if unknown and the result is loaded into the output register;
//   a new item is taken only once the result of the last one is loaded, and
//   the single table read port sets the length of the scan.
// reset:
//   rst_n clears the table fill count (table empty) and sets all ports active.
// stall:
//   the result sits in an output register; the next item is accepted and
//   scanned while it waits, and only the final load waits for out_tready.
module mac_learning_switch_forward
  import mlsf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: src_mac[47:0], dst_mac[95:48], ingress_port[98:96], zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,
  // out_tdata: egress_mask[7:0], flooded[8], learned[9], table_full[10], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  mlsf_cmd_t cmd;
  mlsf_sts_t sts;

  logic [EGR_W-1:0] port_mask_r;
  logic [EGR_W-1:0] egress_mask;
  logic             flooded, learned, table_full;
  logic             cfg_wr;

  // configuration register, written in the apb access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_mask_r <= PORT_MASK_RESET;
    end else if (cfg_wr && cfg_paddr == REG_PORT_ACTIVE_MASK) begin
      port_mask_r <= cfg_pwdata[EGR_W-1:0];
    end
  end

  // unmapped addresses read as zero
  assign cfg_prdata = (cfg_paddr == REG_PORT_ACTIVE_MASK) ? 32'(port_mask_r) : 32'd0;

  // sequencer: accept, scan, learn, load result
  mlsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // mac table and decision datapath
  mlsf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .src_mac          (in_tdata[MAC_W-1:0]),
    .dst_mac          (in_tdata[2*MAC_W-1:MAC_W]),
    .ingress_port     (in_tdata[2*MAC_W+PORT_W-1:2*MAC_W]),
    .port_active_mask (port_mask_r),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .egress_mask      (egress_mask),
    .flooded          (flooded),
    .learned          (learned),
    .table_full       (table_full)
  );

  // result packing, egress mask in the lowest bits and zero pad at the top
  assign out_tdata = {5'd0, table_full, learned, flooded, egress_mask};

endmodule

// File: dv/testbench.sv
// self-checking testbench for the learning switch forwarding decision block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlsf_pkg::*;

  // generous bound for about 500 items, taken several times over
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_SEGMENTS = 6;
  localparam int SEGMENT_ITEMS = 75;
  localparam int POOL_SIZE = 48;
  localparam int DRAIN_CYCLES = 80;
  // ports that exist, as bits of the egress mask
  localparam logic [EGR_W-1:0] PORTS_PRESENT =
    (NUM_PORTS >= EGR_W) ? {EGR_W{1'b1}} : EGR_W'((1 << NUM_PORTS) - 1);

  // one frame header, packed exactly as it travels in in_tdata (src in the low bits)
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  dst;
    logic [MAC_W-1:0]  src;
  } frame_hdr_t;

  // one forwarding decision
  typedef struct packed {
    logic [EGR_W-1:0] egress;
    logic             flooded;
    logic             learned;
    logic             table_full;
  } decision_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  mac_learning_switch_forward DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the mac table and the port enable register
  logic [MAC_W-1:0]  station_mac[TABLE_DEPTH];
  logic [PORT_W-1:0] station_port[TABLE_DEPTH];
  int                station_count = 0;
  logic [EGR_W-1:0]  active_ports = PORT_MASK_RESET;

  frame_hdr_t pending_hdrs[$];        // headers waiting for the driver
  decision_t  expected_decisions[$];  // decisions of accepted headers, oldest first
  logic [MAC_W-1:0] station_pool[POOL_SIZE];
  logic [MAC_W-1:0] fresh_macs[$];    // one-off sources, reused as destinations

  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hdrs_sent = 0;
  int hdrs_issued = 0;
  int decisions_checked = 0;
  int learns_seen = 0;
  int fulls_seen = 0;
  int floods_seen = 0;
  int mask_settings = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
             what, cycle_count, got, want);
    mismatches++;
  endtask

  // linear search oldest to newest, -1 on a miss
  function automatic int find_station(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < station_count; i++) begin
      if (station_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // learn the source, then look up the destination; updates the shadow table
  function automatic decision_t forward_decision(input frame_hdr_t h);
    decision_t        d;
    int               hit_idx;
    logic [EGR_W-1:0] allowed;
    d = '0;
    if (find_station(h.src) < 0) begin
      if (station_count < TABLE_DEPTH) begin
        station_mac[station_count] = h.src;
        station_port[station_count] = h.port;
        station_count++;
        d.learned = 1'b1;
      end else begin
        d.table_full = 1'b1;
      end
    end
    // ingress port and blocked ports never get the frame
    allowed = PORTS_PRESENT & active_ports & ~(EGR_W'(1) << h.port);
    hit_idx = find_station(h.dst);
    if (hit_idx >= 0) begin
      d.egress = allowed & (EGR_W'(1) << station_port[hit_idx]);
      d.flooded = 1'b0;
    end else begin
      d.egress = allowed;
      d.flooded = 1'b1;
    end
    return d;
  endfunction

  function automatic frame_hdr_t hdr(input logic [MAC_W-1:0] src,
                                     input logic [MAC_W-1:0] dst,
                                     input logic [PORT_W-1:0] port);
    frame_hdr_t h;
    h.src = src;
    h.dst = dst;
    h.port = port;
    return h;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[MAC_W-1:0];
  endfunction

  // mostly addresses from a station pool so lookups hit and the table fills slowly,
  // with one-off sources, self-addressed frames and broadcast mixed in
  function automatic frame_hdr_t random_header();
    frame_hdr_t h;
    int         r;
    r = $urandom_range(99);
    if (r < 85) begin
      h.src = station_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      h.src = rand_mac();
      fresh_macs.push_back(h.src);
    end
    r = $urandom_range(99);
    if (r < 55) begin
      h.dst = station_pool[$urandom_range(POOL_SIZE - 1)];
    end else if (r < 70 && fresh_macs.size() > 0) begin
      h.dst = fresh_macs[$urandom_range(fresh_macs.size() - 1)];
    end else if (r < 80) begin
      h.dst = h.src;
    end else if (r < 85) begin
      h.dst = '1;
    end else begin
      h.dst = rand_mac();
    end
    h.port = PORT_W'($urandom_range(NUM_PORTS - 1));
    return h;
  endfunction

  // run-time bound
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions still due",
               cycle_count, expected_decisions.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // driver: predicts each accepted item, then offers the next one or a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_decisions.push_back(forward_decision(frame_hdr_t'(in_tdata[98:0])));
        hdrs_sent++;
      end
      // the slot is free once the current item is gone or none is offered
      if (!in_tvalid || in_tready) begin
        if (pending_hdrs.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, pending_hdrs.pop_front()};
          hdrs_issued++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  // monitor: every accepted result against the oldest expected decision
  always @(posedge clk) begin
    decision_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_decisions.size() == 0) begin
        report_mismatch("result with no frame pending", 64'(out_tdata), 64'd0);
      end else begin
        want = expected_decisions.pop_front();
        decisions_checked++;
        if (out_tdata[7:0] !== want.egress)
          report_mismatch("egress_mask", 64'(out_tdata[7:0]), 64'(want.egress));
        if (out_tdata[8] !== want.flooded)
          report_mismatch("flooded", 64'(out_tdata[8]), 64'(want.flooded));
        if (out_tdata[9] !== want.learned)
          report_mismatch("learned", 64'(out_tdata[9]), 64'(want.learned));
        if (out_tdata[10] !== want.table_full)
          report_mismatch("table_full", 64'(out_tdata[10]), 64'(want.table_full));
        if (want.learned) learns_seen++;
        if (want.table_full) fulls_seen++;
        if (want.flooded) floods_seen++;
      end
    end
  end

  // apb write of the port enable register, then read it back
  task automatic program_mask(input logic [EGR_W-1:0] mask);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_PORT_ACTIVE_MASK << 2;
    cfg_pwdata <= 32'(mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    active_ports = mask;
    mask_settings++;
    // read access
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(mask))
      report_mismatch("port_active_mask read back", 64'(cfg_prdata), 64'(mask));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // wait until every queued item has gone in and its decision has come out;
  // counts handed to the driver so an item just popped is never missed
  task automatic wait_drained();
    while (pending_hdrs.size() > 0 || hdrs_issued != decisions_checked)
      @(posedge clk);
  endtask

  task automatic set_pace(input int gap_pct, input int stall_pct);
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  // stimulus sequencer
  initial begin
    logic [EGR_W-1:0] seg_mask;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(11, 83);

    // directed: all ports enabled
    program_mask(8'hFF);
    pending_hdrs.push_back(hdr(48'h0, 48'h0, 3'd0));                 // self-addressed
    pending_hdrs.push_back(hdr('1, 48'h0, 3'd7));                    // hit on port 0
    pending_hdrs.push_back(hdr(48'h0000_0000_00A1, '1, 3'd3));       // hit on port 7
    pending_hdrs.push_back(hdr(48'h0000_0000_00B2, 48'h0000_0000_00C3, 3'd5)); // flood
    pending_hdrs.push_back(hdr(48'h0, 48'h0000_0000_00A1, 3'd4));    // known source moves
    pending_hdrs.push_back(hdr(48'h0000_0000_00C3, 48'h0000_0000_00B2, 3'd5)); // ingress hit
    pending_hdrs.push_back(hdr(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 3'd0));
    pending_hdrs.push_back(hdr(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 3'd7));
    pending_hdrs.push_back(hdr(48'h8000_0000_0001, 48'h0000_0000_0001, 3'd2));
    pending_hdrs.push_back(hdr(48'h0000_0000_0001, 48'h8000_0000_0001, 3'd6));
    wait_drained();

    // directed: ports 0 and 7 blocked
    program_mask(8'h7E);
    pending_hdrs.push_back(hdr(48'h0000_0000_00B2, 48'h0, 3'd5));    // hit on blocked port
    pending_hdrs.push_back(hdr(48'h0000_0000_00E4, 48'h1234_5678_9ABC, 3'd1)); // masked flood
    pending_hdrs.push_back(hdr('1, '1, 3'd7));                       // self, blocked port
    pending_hdrs.push_back(hdr(48'h0000_0000_00A1, 48'h0000_0000_00E4, 3'd3));
    wait_drained();

    // random: each idling mode spans two segments with different port masks
    foreach (station_pool[i]) station_pool[i] = rand_mac();
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      case (seg / 2)
        0: set_pace(11, 83);
        1: set_pace(83, 11);
        default: set_pace(0, 0);
      endcase
      case (seg)
        1: seg_mask = 8'h00;
        3: seg_mask = 8'hFF;
        default: seg_mask = EGR_W'($urandom_range(255));
      endcase
      program_mask(seg_mask);
      repeat (SEGMENT_ITEMS) pending_hdrs.push_back(random_header());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_decisions.size() != 0)
      report_mismatch("decisions never delivered", 64'(expected_decisions.size()), 64'd0);

    $display("sent %0d frame headers under %0d port masks, checked %0d decisions",
             hdrs_sent, mask_settings, decisions_checked);
    $display("%0d sources learned, %0d with the table full, %0d floods, %0d table entries",
             learns_seen, fulls_seen, floods_seen, station_count);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
